// ----- rtl/dns_response_address_extractor_top_assert.svh -----
// Assertion macros for the DNS response address extractor.
// Included by the top level; expects clk and arst_n in scope.
`ifndef DNS_RESPONSE_ADDRESS_EXTRACTOR_TOP_ASSERT_SVH
`define DNS_RESPONSE_ADDRESS_EXTRACTOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DRE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dre assertion failed");

// Next-cycle implication, checked outside reset.
`define DRE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dre assertion failed");

`endif

// ----- rtl/dre_pkg.sv -----
// Shared types and constants for the DNS response address extractor.
// No dependencies; used by the parser, the result queue and the top level.
package dre_pkg;

	localparam logic [2:0] ST_FOUND   = 3'd0;
	localparam logic [2:0] ST_SERVER  = 3'd1;
	localparam logic [2:0] ST_UNSUP   = 3'd2;
	localparam logic [2:0] ST_IGNORED = 3'd3;
	localparam logic [2:0] ST_NONE    = 3'd4;

	localparam logic [15:0] EXPECTED_ID_RESET = 16'h0666;
	localparam logic [0:0]  REG_EXPECTED_ID   = 1'b0;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] address;
	} result_t;

endpackage

// ----- rtl/dre_parser.sv -----
// Byte-wise DNS response parser: holds the per-message state and decides the verdict.
// Depends on dre_pkg for the status codes and the result type.
module dre_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	input  logic [15:0]          expected_id,
	output logic                 res_valid,
	output dre_pkg::result_t     res
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_QNAME,
		PH_QTAIL,
		PH_ANSWER,
		PH_ADDR,
		PH_SKIP,
		PH_DONE
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [3:0]  pos_q, pos_d;
	logic [15:0] id_q, id_d;
	logic        qr_q, qr_d;
	logic [3:0]  rcode_q, rcode_d;
	logic [15:0] qleft_q, qleft_d;
	logic [15:0] aleft_q, aleft_d;
	logic [7:0]  label_q, label_d;
	logic [15:0] rtype_q, rtype_d;
	logic [15:0] rclass_q, rclass_d;
	logic [15:0] rdlen_q, rdlen_d;
	logic [23:0] addr_q, addr_d;

	logic [15:0] qleft_dec, aleft_dec, rdlen_dec, rdlen_new;
	logic        rv;
	dre_pkg::result_t r;

	assign qleft_dec = qleft_q - 16'd1;
	assign aleft_dec = aleft_q - 16'd1;
	assign rdlen_dec = rdlen_q - 16'd1;
	assign rdlen_new = {rdlen_q[7:0], data_byte};

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		id_d     = id_q;
		qr_d     = qr_q;
		rcode_d  = rcode_q;
		qleft_d  = qleft_q;
		aleft_d  = aleft_q;
		label_d  = label_q;
		rtype_d  = rtype_q;
		rclass_d = rclass_q;
		rdlen_d  = rdlen_q;
		addr_d   = addr_q;
		rv       = 1'b0;
		r        = '0;

		case (phase_q)
			PH_HEADER: begin
				case (pos_q)
					4'd0, 4'd1: id_d = {id_q[7:0], data_byte};
					4'd2: qr_d = data_byte[7];
					4'd3: rcode_d = data_byte[3:0];
					4'd4, 4'd5: qleft_d = {qleft_q[7:0], data_byte};
					4'd6, 4'd7: aleft_d = {aleft_q[7:0], data_byte};
					default: ;
				endcase
				if (pos_q >= 4'd11) begin
					pos_d = '0;
					if (id_q != expected_id || !qr_q) begin
						rv = 1'b1;
						r.status = dre_pkg::ST_IGNORED;
						phase_d = PH_DONE;
					end else if (rcode_q != 4'd0 || aleft_q == 16'd0) begin
						rv = 1'b1;
						r.status = dre_pkg::ST_SERVER;
						phase_d = PH_DONE;
					end else begin
						phase_d = (qleft_q == 16'd0) ? PH_ANSWER : PH_QNAME;
					end
				end else begin
					pos_d = pos_q + 4'd1;
				end
			end
			PH_QNAME: begin
				if (label_q != 8'd0) begin
					label_d = label_q - 8'd1;
				end else if (data_byte == 8'd0) begin
					phase_d = PH_QTAIL;
					pos_d   = '0;
				end else begin
					label_d = data_byte;
				end
			end
			PH_QTAIL: begin
				if (pos_q >= 4'd3) begin
					pos_d   = '0;
					qleft_d = qleft_dec;
					phase_d = (qleft_dec == 16'd0) ? PH_ANSWER : PH_QNAME;
				end else begin
					pos_d = pos_q + 4'd1;
				end
			end
			PH_ANSWER: begin
				if (pos_q == 4'd0 && data_byte <= 8'd64) begin
					// Only a compressed (pointer) owner name is supported.
					rv = 1'b1;
					r.status = dre_pkg::ST_UNSUP;
					phase_d = PH_DONE;
				end else begin
					case (pos_q)
						4'd2, 4'd3: rtype_d = {rtype_q[7:0], data_byte};
						4'd4, 4'd5: rclass_d = {rclass_q[7:0], data_byte};
						4'd10, 4'd11: rdlen_d = rdlen_new;
						default: ;
					endcase
					if (pos_q >= 4'd11) begin
						pos_d = '0;
						if (rclass_q == 16'd1 && rtype_q == 16'd1) begin
							addr_d  = '0;
							phase_d = PH_ADDR;
						end else if (rdlen_new == 16'd0) begin
							aleft_d = aleft_dec;
							if (aleft_dec == 16'd0) begin
								rv = 1'b1;
								r.status = dre_pkg::ST_NONE;
								phase_d = PH_DONE;
							end else begin
								phase_d = PH_ANSWER;
							end
						end else begin
							phase_d = PH_SKIP;
						end
					end else begin
						pos_d = pos_q + 4'd1;
					end
				end
			end
			PH_ADDR: begin
				addr_d = {addr_q[15:0], data_byte};
				if (pos_q >= 4'd3) begin
					pos_d = '0;
					rv = 1'b1;
					r.status = dre_pkg::ST_FOUND;
					r.address = {addr_q, data_byte};
					phase_d = PH_DONE;
				end else begin
					pos_d = pos_q + 4'd1;
				end
			end
			PH_SKIP: begin
				rdlen_d = rdlen_dec;
				if (rdlen_dec == 16'd0) begin
					aleft_d = aleft_dec;
					if (aleft_dec == 16'd0) begin
						rv = 1'b1;
						r.status = dre_pkg::ST_NONE;
						phase_d = PH_DONE;
					end else begin
						phase_d = PH_ANSWER;
						pos_d   = '0;
					end
				end
			end
			default: ;
		endcase

		// The final byte closes the message; report truncation if nothing was decided.
		if (last_byte) begin
			if (!rv && phase_q != PH_DONE) begin
				rv = 1'b1;
				r.status = dre_pkg::ST_NONE;
				r.address = '0;
			end
			phase_d  = PH_HEADER;
			pos_d    = '0;
			id_d     = '0;
			qr_d     = 1'b0;
			rcode_d  = '0;
			qleft_d  = '0;
			aleft_d  = '0;
			label_d  = '0;
			rtype_d  = '0;
			rclass_d = '0;
			rdlen_d  = '0;
			addr_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			id_q     <= '0;
			qr_q     <= 1'b0;
			rcode_q  <= '0;
			qleft_q  <= '0;
			aleft_q  <= '0;
			label_q  <= '0;
			rtype_q  <= '0;
			rclass_q <= '0;
			rdlen_q  <= '0;
			addr_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			id_q     <= id_d;
			qr_q     <= qr_d;
			rcode_q  <= rcode_d;
			qleft_q  <= qleft_d;
			aleft_q  <= aleft_d;
			label_q  <= label_d;
			rtype_q  <= rtype_d;
			rclass_q <= rclass_d;
			rdlen_q  <= rdlen_d;
			addr_q   <= addr_d;
		end
	end

	assign res_valid = step && rv;
	assign res       = r;

endmodule

// ----- rtl/dre_result_fifo.sv -----
// Two-entry result queue that decouples the parser from the output stream.
// Depends on dre_pkg for the result type.
module dre_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  dre_pkg::result_t  wr_data,
	output logic              full,
	output logic              rd_valid,
	input  logic              rd_ready,
	output dre_pkg::result_t  rd_data
);

	dre_pkg::result_t entry_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	logic             pop;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/dns_response_address_extractor_top.sv -----
// DNS response address extractor: one verdict per DNS response message.
// Bytes come in on the slave stream (s_tdata = data_byte, s_tlast marks the final byte).
// Each message yields exactly one transfer on the master stream: status and address.
// The verdict is sent on the byte that decides it; later bytes up to tlast are consumed.
// An accepted byte sits in the input register and is parsed from there while the queue
// has room; its verdict is registered in the result queue, which drives m_tvalid.
// Throughput is one byte per cycle while the result queue is not full; the per-byte
// update is a single pass of counter and compare logic in the parser.
// Results wait in a two-entry queue. When the receiver stalls and the queue fills,
// the parser holds its byte and s_tready drops until a transfer drains an entry.
// expected_id sits in the APB register at byte address 0 (reset 0x666); write it only
// while no message is in flight.
// Reset clears the parser to the header phase and empties the queue.
// Depends on dre_pkg, dre_parser, dre_result_fifo and the assertion macro header.
`include "dns_response_address_extractor_top_assert.svh"

module dns_response_address_extractor_top (
	input  logic        clk,
	input  logic        arst_n,
	// APB register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input byte stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	// Verdict stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [2:0] status, [34:3] address, [39:35] zero
);

	logic [15:0]      expected_id_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic             fifo_full;
	logic             advance;
	logic             res_valid;
	dre_pkg::result_t res;
	dre_pkg::result_t out_res;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == dre_pkg::REG_EXPECTED_ID) ? {16'd0, expected_id_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_id_q <= dre_pkg::EXPECTED_ID_RESET;
		end else if (psel && penable && pwrite && paddr[2] == dre_pkg::REG_EXPECTED_ID) begin
			expected_id_q <= pwdata[15:0];
		end
	end

	// Input register; it refills in the same cycle that the parser consumes it.
	assign advance  = valid_s1 && !fifo_full;
	assign s_tready = !valid_s1 || !fifo_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	dre_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.data_byte   (byte_s1),
		.last_byte   (last_s1),
		.expected_id (expected_id_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	dre_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (res_valid),
		.wr_data  (res),
		.full     (fifo_full),
		.rd_valid (m_tvalid),
		.rd_ready (m_tready),
		.rd_data  (out_res)
	);

	assign m_tdata = {5'd0, out_res.address, out_res.status};

	// A verdict other than found never carries an address.
	`DRE_ASSERT_NOW(a_addr_zero, m_tvalid && m_tdata[2:0] != dre_pkg::ST_FOUND, m_tdata[34:3] == 32'd0)
	// Status codes stay within the defined set.
	`DRE_ASSERT_NOW(a_status_range, m_tvalid, m_tdata[2:0] <= dre_pkg::ST_NONE)
	// A byte held back by a full queue stays put until the parser takes it.
	`DRE_ASSERT_NEXT(a_hold_s1, valid_s1 && fifo_full, valid_s1 && byte_s1 == $past(byte_s1))

endmodule

// ----- test/dns_response_address_extractor_checker.sv -----
// Checker for the DNS response address extractor: watches the APB port and both streams.
// Keeps its own parser of the byte stream, predicts one verdict per message and compares.
// Depends on dre_pkg for the status codes, the register index and the result layout.
module dre_verdict_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // [2:0] status, [34:3] address, [39:35] zero
	output int          fail_count,
	output int          pending
);

	typedef enum logic [3:0] {
		P_HEADER, P_QNAME, P_QTAIL, P_ANSWER, P_ADDR, P_SKIP, P_DONE
	} parse_phase_t;

	logic [15:0]  exp_id;
	parse_phase_t phase;
	logic [3:0]   field_pos;
	logic [15:0]  hdr_id, hdr_flags, qd_left, an_left;
	logic [7:0]   label_left;
	logic [15:0]  rr_type, ans_class, rd_left;
	logic [31:0]  addr_acc;
	logic         decided;

	logic             verdict_ready;
	dre_pkg::result_t verdict;
	dre_pkg::result_t expected_verdicts[$];
	dre_pkg::result_t want;
	int               mismatches;

	task restart_message();
		phase = P_HEADER;
		field_pos = '0;
		hdr_id = '0;
		hdr_flags = '0;
		qd_left = '0;
		an_left = '0;
		label_left = '0;
		rr_type = '0;
		ans_class = '0;
		rd_left = '0;
		addr_acc = '0;
		decided = 1'b0;
	endtask

	task conclude(input logic [2:0] st, input logic [31:0] addr);
		verdict_ready = 1'b1;
		verdict.status = st;
		verdict.address = addr;
		decided = 1'b1;
		phase = P_DONE;
	endtask

	task close_record();
		an_left = an_left - 16'd1;
		if (an_left == 0) begin
			conclude(dre_pkg::ST_NONE, '0);
		end else begin
			phase = P_ANSWER;
			field_pos = '0;
		end
	endtask

	task advance_parser(input logic [7:0] b, input logic is_last);
		verdict_ready = 1'b0;
		verdict = '0;
		case (phase)
			P_HEADER: begin
				if (field_pos < 2) hdr_id = {hdr_id[7:0], b};
				else if (field_pos < 4) hdr_flags = {hdr_flags[7:0], b};
				else if (field_pos < 6) qd_left = {qd_left[7:0], b};
				else if (field_pos < 8) an_left = {an_left[7:0], b};
				if (field_pos >= 11) begin
					field_pos = '0;
					// The header is judged only once all twelve bytes are in.
					if (hdr_id != exp_id || !hdr_flags[15])
						conclude(dre_pkg::ST_IGNORED, '0);
					else if (hdr_flags[3:0] != 0 || an_left == 0)
						conclude(dre_pkg::ST_SERVER, '0);
					else
						phase = (qd_left == 0) ? P_ANSWER : P_QNAME;
				end else begin
					field_pos++;
				end
			end
			P_QNAME: begin
				// Any nonzero length byte is a plain label length, pointers included.
				if (label_left != 0) begin
					label_left--;
				end else if (b == 0) begin
					phase = P_QTAIL;
					field_pos = '0;
				end else begin
					label_left = b;
				end
			end
			P_QTAIL: begin
				if (field_pos >= 3) begin
					field_pos = '0;
					qd_left = qd_left - 16'd1;
					phase = (qd_left == 0) ? P_ANSWER : P_QNAME;
				end else begin
					field_pos++;
				end
			end
			P_ANSWER: begin
				if (field_pos == 0 && b <= 8'd64) begin
					conclude(dre_pkg::ST_UNSUP, '0);
				end else begin
					if (field_pos == 2 || field_pos == 3) rr_type = {rr_type[7:0], b};
					else if (field_pos == 4 || field_pos == 5) ans_class = {ans_class[7:0], b};
					else if (field_pos == 10 || field_pos == 11) rd_left = {rd_left[7:0], b};
					if (field_pos >= 11) begin
						field_pos = '0;
						if (ans_class == 16'd1 && rr_type == 16'd1) begin
							addr_acc = '0;
							phase = P_ADDR;
						end else if (rd_left == 0) begin
							close_record();
						end else begin
							phase = P_SKIP;
						end
					end else begin
						field_pos++;
					end
				end
			end
			P_ADDR: begin
				addr_acc = {addr_acc[23:0], b};
				if (field_pos >= 3) begin
					field_pos = '0;
					conclude(dre_pkg::ST_FOUND, addr_acc);
				end else begin
					field_pos++;
				end
			end
			P_SKIP: begin
				rd_left = rd_left - 16'd1;
				if (rd_left == 0) close_record();
			end
			default: ;
		endcase
		if (is_last) begin
			if (!verdict_ready && !decided) begin
				verdict_ready = 1'b1;
				verdict.status = dre_pkg::ST_NONE;
				verdict.address = '0;
			end
			restart_message();
		end
		if (verdict_ready) expected_verdicts.push_back(verdict);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_id = dre_pkg::EXPECTED_ID_RESET;
			restart_message();
			expected_verdicts.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready &&
					paddr == 3'(4 * dre_pkg::REG_EXPECTED_ID))
				exp_id = pwdata[15:0];
			if (m_tvalid && m_tready) begin
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected verdict: status %0d address %h",
							m_tdata[2:0], m_tdata[34:3]);
				end else begin
					want = expected_verdicts.pop_front();
					if (m_tdata[2:0] != want.status || m_tdata[34:3] != want.address ||
							m_tdata[39:35] != '0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("verdict mismatch: got status %0d address %h pad %h, %s %0d %s %h",
								m_tdata[2:0], m_tdata[34:3], m_tdata[39:35],
								"want status", want.status, "address", want.address);
					end
				end
			end
			if (s_tvalid && s_tready) advance_parser(s_tdata, s_tlast);
			fail_count <= mismatches;
			pending <= expected_verdicts.size();
		end
	end

endmodule

// ----- test/tb_dns_response_address_extractor_top.sv -----
// Testbench top for the DNS response address extractor: clock, reset, APB writes and
// randomly paced byte and verdict streams. Checking is done by dre_verdict_checker.
// Depends on dre_pkg, dns_response_address_extractor_top and the checker module.
module tb_dns_response_address_extractor_top;

	localparam int LIMIT = 1_000_000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid, s_tready, s_tlast;
	logic [7:0]  s_tdata;
	logic        m_tvalid, m_tready;
	logic [39:0] m_tdata;
	int          fail_count, pending;

	logic [7:0]  msg[$];
	logic [15:0] cur_id;
	int          bytes_counted = 0;
	int          tx_calm = 0, rx_calm = 0, rx_hold, rx_gap;
	int          cycles = 0;

	dns_response_address_extractor_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	dre_verdict_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones, and now and then a long stretch without any.
	function automatic int pick_gap(inout int calm);
		int roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			calm = $urandom_range(40, 200);
			return 0;
		end
		if (roll < 55) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold <= 0;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
		end else begin
			rx_gap = pick_gap(rx_calm);
			if (rx_gap > 0) begin
				m_tready <= 1'b0;
				rx_hold <= rx_gap - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task put16(input logic [15:0] v);
		msg.push_back(v[15:8]);
		msg.push_back(v[7:0]);
	endtask

	task put32(input logic [31:0] v);
		put16(v[31:16]);
		put16(v[15:0]);
	endtask

	task add_header(input logic [15:0] id, input logic [15:0] flags,
			input logic [15:0] qd, input logic [15:0] an);
		put16(id);
		put16(flags);
		put16(qd);
		put16(an);
		put32($urandom);
	endtask

	task add_label(input int len);
		msg.push_back(8'(len));
		repeat (len) msg.push_back(8'($urandom));
	endtask

	task add_question();
		repeat ($urandom_range(0, 3))
			add_label(($urandom_range(0, 19) == 0) ? $urandom_range(13, 255)
				: $urandom_range(1, 12));
		msg.push_back(8'h00);
		put32($urandom);
	endtask

	task add_record(input logic [7:0] name0, input logic [15:0] rtype,
			input logic [15:0] rclass, input logic [15:0] rdlen, input int n);
		msg.push_back(name0);
		msg.push_back(8'($urandom));
		put16(rtype);
		put16(rclass);
		put32($urandom);
		put16(rdlen);
		repeat (n) msg.push_back(8'($urandom));
	endtask

	task add_answer(input bit is_a, input bit broken);
		logic [7:0]  name0;
		logic [15:0] t, c, len;
		name0 = broken ? 8'($urandom_range(0, 64)) : 8'($urandom_range(65, 255));
		if (is_a) begin
			// The address is read whatever rdlength claims.
			len = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 12)) : 16'd4;
			add_record(name0, 16'd1, 16'd1, len, 4);
		end else begin
			case ($urandom_range(0, 2))
				0: begin t = 16'd1; c = 16'($urandom); end
				1: begin t = 16'($urandom_range(0, 33)); c = 16'd1; end
				default: begin t = 16'($urandom); c = 16'($urandom_range(0, 4)); end
			endcase
			if (t == 16'd1 && c == 16'd1) c = 16'd3;
			len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(13, 60))
				: 16'($urandom_range(0, 12));
			add_record(name0, t, c, len, len);
		end
	endtask

	// flaw: 0 clean, 1 wrong id, 2 not a response, 3 rcode set, 4 no answers,
	// 5 an uncompressed answer name somewhere.
	task build_reply(input int flaw);
		int qd, an, hit, bad;
		logic [15:0] id, flags;
		msg.delete();
		qd = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
		an = $urandom_range(1, 4);
		hit = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, an);
		bad = (flaw == 5) ? $urandom_range(1, an) : 0;
		id = cur_id;
		flags = {1'b1, 11'($urandom), 4'h0};
		case (flaw)
			1: id = $urandom_range(0, 1) ? cur_id ^ (16'd1 << $urandom_range(0, 15))
				: cur_id ^ 16'($urandom_range(1, 16'hFFFF));
			2: flags[15] = 1'b0;
			3: flags[3:0] = 4'($urandom_range(1, 15));
			4: an = 0;
			default: ;
		endcase
		add_header(id, flags, 16'(qd), 16'(an));
		repeat (qd) add_question();
		for (int i = 1; i <= an; i++) add_answer(i == hit, i == bad);
	endtask

	task send_msg(input int keep);
		int gap;
		for (int i = 0; i < keep; i++) begin
			gap = pick_gap(tx_calm);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= msg[i];
			s_tlast <= (i == keep - 1);
			@(posedge clk);
			while (!s_tready) @(posedge clk);
		end
		bytes_counted += keep;
	endtask

	task send_whole();
		send_msg(msg.size());
	endtask

	task wait_until_settled();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task write_expected_id(input logic [15:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * dre_pkg::REG_EXPECTED_ID);
		pwdata <= {16'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_id = v;
	endtask

	task run_directed();
		// Smallest found case, all address bits set, last flag on the deciding byte.
		msg.delete();
		add_header(cur_id, 16'h8180, 16'd0, 16'd1);
		add_record(8'hC0, 16'd1, 16'd1, 16'd4, 0);
		put32(32'hFFFF_FFFF);
		send_whole();
		// Question labels of length 64 and 255 are skipped as plain labels.
		msg.delete();
		add_header(cur_id, 16'h8180, 16'd1, 16'd1);
		add_label(64);
		add_label(255);
		msg.push_back(8'h00);
		put32($urandom);
		add_record(8'hFF, 16'd1, 16'd1, 16'd4, 0);
		put32(32'h0000_0000);
		send_whole();
		// Wrong id, then a query rather than a response.
		msg.delete();
		add_header(cur_id ^ 16'h0001, 16'h8180, 16'd0, 16'd1);
		add_record(8'hC0, 16'd1, 16'd1, 16'd4, 4);
		send_whole();
		msg.delete();
		add_header(cur_id, 16'h0100, 16'd0, 16'd1);
		add_record(8'hC0, 16'd1, 16'd1, 16'd4, 4);
		send_whole();
		// Server error, and a header with no answers that ends on its twelfth byte.
		msg.delete();
		add_header(cur_id, 16'h800F, 16'd0, 16'd1);
		add_record(8'hC0, 16'd1, 16'd1, 16'd4, 4);
		send_whole();
		msg.delete();
		add_header(cur_id, 16'hFFF0, 16'd0, 16'd0);
		send_whole();
		// Answer names at the compression boundary.
		msg.delete();
		add_header(cur_id, 16'h8180, 16'd0, 16'd1);
		add_record(8'd64, 16'd1, 16'd1, 16'd4, 4);
		send_whole();
		msg.delete();
		add_header(cur_id, 16'h8180, 16'd0, 16'd1);
		add_record(8'd65, 16'd1, 16'd1, 16'd4, 4);
		send_whole();
		// Answers run out with no A record; trailing bytes are ignored.
		msg.delete();
		add_header(cur_id, 16'h8180, 16'd0, 16'd2);
		add_record(8'hC0, 16'd1, 16'd2, 16'd0, 0);
		add_record(8'hC0, 16'd28, 16'd1, 16'd3, 3);
		put16(16'h00FF);
		msg.push_back(8'h00);
		send_whole();
		// A record with rdlength zero still takes the next four bytes as address.
		msg.delete();
		add_header(cur_id, 16'h8180, 16'd0, 16'd3);
		add_record(8'hC0, 16'hFFFF, 16'hFFFF, 16'd1, 1);
		add_record(8'hC0, 16'd1, 16'd1, 16'd0, 0);
		put32(32'h8000_0001);
		add_record(8'hC0, 16'd1, 16'd1, 16'd4, 4);
		send_whole();
		// Truncated messages: inside the header, a single byte, and deep in the questions.
		msg.delete();
		add_header(cur_id, 16'h8180, 16'd0, 16'd1);
		send_msg(5);
		msg.delete();
		msg.push_back(8'h00);
		send_whole();
		msg.delete();
		add_header(cur_id, 16'h8000, 16'hFFFF, 16'hFFFF);
		put16(16'h0300);
		msg.push_back(8'hFF);
		send_whole();
	endtask

	task run_random(input int budget);
		int start, kind, keep;
		start = bytes_counted;
		while (bytes_counted - start < budget) begin
			if ($urandom_range(0, 19) == 0) wait_until_settled();
			kind = $urandom_range(0, 99);
			if (kind < 85) begin
				if (kind < 50) build_reply(0);
				else if (kind < 62) build_reply($urandom_range(1, 4));
				else if (kind < 70) build_reply(5);
				else build_reply($urandom_range(0, 1) ? 0 : $urandom_range(1, 5));
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom));
				keep = (kind >= 70) ? $urandom_range(1, msg.size()) : msg.size();
			end else begin
				msg.delete();
				if ($urandom_range(0, 1)) put16(cur_id);
				repeat ($urandom_range(1, 24)) msg.push_back(8'($urandom));
				keep = msg.size();
			end
			send_msg(keep);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		cur_id = dre_pkg::EXPECTED_ID_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random(220);
		for (int p = 0; p < 5; p++) begin
			wait_until_settled();
			case (p)
				0: write_expected_id(16'h0000);
				1: write_expected_id(16'hFFFF);
				4: write_expected_id(dre_pkg::EXPECTED_ID_RESET);
				default: write_expected_id(16'($urandom));
			endcase
			run_random(200);
		end
		wait_until_settled();
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
